@@ rtl/lae_pkg.sv @@
// shared types, codes and the control store of the envelope generator
`default_nettype none
package lae_pkg;

	localparam int TIME_W = 24;
	localparam int LVL_W  = 16;
	localparam int NUM_W  = TIME_W + LVL_W + 1;
	localparam int QUO_W  = LVL_W + 1;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [TIME_W-1:0] ATTACK_TIME_RST   = 24'd441;
	localparam logic [TIME_W-1:0] DECAY_TIME_RST    = 24'd441;
	localparam logic [LVL_W-1:0]  DECAY_LEVEL_RST   = 16'd52428;
	localparam logic [TIME_W-1:0] SUSTAIN_TIME_RST  = 24'd4410;
	localparam logic [LVL_W-1:0]  SUSTAIN_LEVEL_RST = 16'd39321;
	localparam logic [TIME_W-1:0] RELEASE_TIME_RST  = 24'd4410;

	localparam logic [LVL_W-1:0]  MAX_LEVEL  = 16'hFFFF;
	localparam logic [QUO_W-1:0]  FULL_SCALE = 17'h10000;
	localparam logic [TIME_W-1:0] COUNT_MAX  = 24'hFFFFFF;

	// commands
	localparam logic [1:0] CMD_REQ     = 2'd0;
	localparam logic [1:0] CMD_PRESS   = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;

	// register indexes
	localparam logic [2:0] REG_ATTACK_TIME   = 3'd0;
	localparam logic [2:0] REG_DECAY_TIME    = 3'd1;
	localparam logic [2:0] REG_DECAY_LEVEL   = 3'd2;
	localparam logic [2:0] REG_SUSTAIN_TIME  = 3'd3;
	localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd4;
	localparam logic [2:0] REG_RELEASE_TIME  = 3'd5;

	// envelope segments
	localparam logic [1:0] SEG_ATTACK  = 2'd0;
	localparam logic [1:0] SEG_DECAY   = 2'd1;
	localparam logic [1:0] SEG_RAMP    = 2'd2;
	localparam logic [1:0] SEG_RELEASE = 2'd3;

	// datapath operations
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_DECODE  = 3'd1;
	localparam logic [2:0] OP_SELECT  = 3'd2;
	localparam logic [2:0] OP_MUL     = 3'd3;
	localparam logic [2:0] OP_DIVINIT = 3'd4;
	localparam logic [2:0] OP_DIVSTEP = 3'd5;
	localparam logic [2:0] OP_FINISH  = 3'd6;
	localparam logic [2:0] OP_EMIT    = 3'd7;

	// sequencing conditions
	localparam logic [2:0] COND_NEXT    = 3'd0;
	localparam logic [2:0] COND_WAIT_IN = 3'd1;
	localparam logic [2:0] COND_NOT_REQ = 3'd2;
	localparam logic [2:0] COND_NO_DIV  = 3'd3;
	localparam logic [2:0] COND_LOOP    = 3'd4;
	localparam logic [2:0] COND_OUT     = 3'd5;

	// program steps
	localparam logic [2:0] PC_WAIT    = 3'd0;
	localparam logic [2:0] PC_DECODE  = 3'd1;
	localparam logic [2:0] PC_SELECT  = 3'd2;
	localparam logic [2:0] PC_MUL     = 3'd3;
	localparam logic [2:0] PC_DIVINIT = 3'd4;
	localparam logic [2:0] PC_DIVSTEP = 3'd5;
	localparam logic [2:0] PC_FINISH  = 3'd6;
	localparam logic [2:0] PC_EMIT    = 3'd7;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] cond;
		logic [2:0] target;
	} ucode_t;

	function automatic ucode_t ucode(input logic [2:0] pc);
		ucode_t w;
		case (pc)
			PC_WAIT:    w = '{op: OP_NONE,    cond: COND_WAIT_IN, target: PC_DECODE};
			PC_DECODE:  w = '{op: OP_DECODE,  cond: COND_NOT_REQ, target: PC_EMIT};
			PC_SELECT:  w = '{op: OP_SELECT,  cond: COND_NO_DIV,  target: PC_EMIT};
			PC_MUL:     w = '{op: OP_MUL,     cond: COND_NEXT,    target: PC_DIVINIT};
			PC_DIVINIT: w = '{op: OP_DIVINIT, cond: COND_NEXT,    target: PC_DIVSTEP};
			PC_DIVSTEP: w = '{op: OP_DIVSTEP, cond: COND_LOOP,    target: PC_DIVSTEP};
			PC_FINISH:  w = '{op: OP_FINISH,  cond: COND_NEXT,    target: PC_EMIT};
			PC_EMIT:    w = '{op: OP_EMIT,    cond: COND_OUT,     target: PC_WAIT};
			default:    w = '{op: OP_NONE,    cond: COND_NEXT,    target: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ rtl/lae_if.sv @@
// command and result channel interfaces of the envelope generator
`default_nettype none
interface lae_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                command;
	logic [lae_pkg::TIME_W-1:0] sample_time;

	modport source (output valid, command, sample_time, input ready);
	modport sink (input valid, command, sample_time, output ready);
endinterface

interface lae_res_if;
	logic                     valid;
	logic                     ready;
	logic [lae_pkg::LVL_W-1:0] level;
	logic                     playing;

	modport source (output valid, level, playing, input ready);
	modport sink (input valid, level, playing, output ready);
endinterface
`default_nettype wire

@@ rtl/linear_adsr_envelope_top.sv @@
// linear adsr envelope generator: apb registers, microcoded sequencer and datapath
//
// Usage: commands arrive on cmd (note press, note release, or a level request
// with the sample count since the press); every command gives one result on
// res carrying the envelope level (unsigned Q0.16) and the playing flag.
// Registers sit on the apb port at 4*index: attack_time, decay_time,
// decay_level, sustain_time, sustain_level, release_time. Write them only
// while the block is idle.
// A short program in a control store runs one command at a time. Press and
// release go from decode straight to the emit step, held requests on a
// segment boundary from decode through select to emit; requests that interpolate
// pass one 24x17 multiply and a 17-step radix-2 divider before finish and emit.
// A new command is not taken until the last one's result is loaded into the
// output register; ready rises as that result is loaded.
// The output register holds a result until it is taken; a new command is
// accepted meanwhile and its result waits in the sequencer until the output
// register frees up.
// Reset (arst_n low) clears the envelope state, loads the default register
// values and empties the output register.
`default_nettype none
module linear_adsr_envelope_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	lae_cmd_if.sink                          cmd,
	lae_res_if.source                        res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lae_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lae_pkg::DATA_W-1:0]  pwdata,
	output logic      [lae_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	// configuration
	logic [lae_pkg::TIME_W-1:0] attack_time_q, decay_time_q, sustain_time_q, release_time_q;
	logic [lae_pkg::LVL_W-1:0]  decay_level_q, sustain_level_q;

	// envelope state
	logic                       note_held_q, active_q;
	logic [lae_pkg::LVL_W-1:0]  level_q, start_level_q;
	logic [lae_pkg::TIME_W-1:0] release_count_q;

	// sequencer and datapath
	logic [2:0]                 pc_q, pc_d;
	lae_pkg::ucode_t            uw;
	logic [1:0]                 cmd_q;
	logic [lae_pkg::TIME_W-1:0] t_q;
	logic [lae_pkg::TIME_W:0]   ad_q;
	logic [lae_pkg::TIME_W+1:0] ads_q;
	logic [1:0]                 seg_q;
	logic                       up_q;
	logic [lae_pkg::TIME_W-1:0] x_q, div_q, rem_q;
	logic [lae_pkg::QUO_W-1:0]  y_q, work_q;
	logic [lae_pkg::NUM_W-1:0]  num_q;
	logic                       ovf_q;
	logic [4:0]                 cnt_q;

	logic                       out_valid_q, out_playing_q;
	logic [lae_pkg::LVL_W-1:0]  out_level_q;

	logic                       cfg_wr, in_acc, out_free, no_div;
	logic [lae_pkg::TIME_W+1:0] t_ext;
	logic [lae_pkg::NUM_W-1:0]  prod;
	logic [lae_pkg::TIME_W:0]   shifted, diff;
	logic                       ge;

	assign uw       = lae_pkg::ucode(pc_q);
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;
	assign in_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = (pc_q == lae_pkg::PC_WAIT);
	assign out_free = !out_valid_q || res.ready;
	assign res.valid   = out_valid_q;
	assign res.level   = out_level_q;
	assign res.playing = out_playing_q;

	assign t_ext   = {2'b00, t_q};
	assign no_div  = note_held_q && (t_ext > {2'b00, attack_time_q})
		&& (t_ext >= {1'b0, ad_q}) && !((t_ext > {1'b0, ad_q}) && (t_ext < ads_q));
	assign prod    = x_q * y_q;
	assign shifted = {rem_q, work_q[lae_pkg::QUO_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = (shifted >= {1'b0, div_q});

	// register read
	always_comb begin
		case (paddr[4:2])
			lae_pkg::REG_ATTACK_TIME:   prdata = {8'h00, attack_time_q};
			lae_pkg::REG_DECAY_TIME:    prdata = {8'h00, decay_time_q};
			lae_pkg::REG_DECAY_LEVEL:   prdata = {16'h0000, decay_level_q};
			lae_pkg::REG_SUSTAIN_TIME:  prdata = {8'h00, sustain_time_q};
			lae_pkg::REG_SUSTAIN_LEVEL: prdata = {16'h0000, sustain_level_q};
			lae_pkg::REG_RELEASE_TIME:  prdata = {8'h00, release_time_q};
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_time_q   <= lae_pkg::ATTACK_TIME_RST;
			decay_time_q    <= lae_pkg::DECAY_TIME_RST;
			decay_level_q   <= lae_pkg::DECAY_LEVEL_RST;
			sustain_time_q  <= lae_pkg::SUSTAIN_TIME_RST;
			sustain_level_q <= lae_pkg::SUSTAIN_LEVEL_RST;
			release_time_q  <= lae_pkg::RELEASE_TIME_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				lae_pkg::REG_ATTACK_TIME:   attack_time_q   <= pwdata[23:0];
				lae_pkg::REG_DECAY_TIME:    decay_time_q    <= pwdata[23:0];
				lae_pkg::REG_DECAY_LEVEL:   decay_level_q   <= pwdata[15:0];
				lae_pkg::REG_SUSTAIN_TIME:  sustain_time_q  <= pwdata[23:0];
				lae_pkg::REG_SUSTAIN_LEVEL: sustain_level_q <= pwdata[15:0];
				lae_pkg::REG_RELEASE_TIME:  release_time_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// step counter
	always_comb begin
		case (uw.cond)
			lae_pkg::COND_WAIT_IN: pc_d = in_acc ? uw.target : pc_q;
			lae_pkg::COND_NOT_REQ: pc_d = (cmd_q != lae_pkg::CMD_REQ) ? uw.target : pc_q + 3'd1;
			lae_pkg::COND_NO_DIV:  pc_d = no_div ? uw.target : pc_q + 3'd1;
			lae_pkg::COND_LOOP:    pc_d = (cnt_q != 5'd0) ? uw.target : pc_q + 3'd1;
			lae_pkg::COND_OUT:     pc_d = out_free ? uw.target : pc_q;
			default:               pc_d = pc_q + 3'd1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q            <= lae_pkg::PC_WAIT;
			note_held_q     <= 1'b0;
			active_q        <= 1'b0;
			level_q         <= '0;
			start_level_q   <= '0;
			release_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if ((uw.op == lae_pkg::OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				lae_pkg::OP_DECODE: begin
					case (cmd_q)
						lae_pkg::CMD_PRESS: begin
							note_held_q   <= 1'b1;
							active_q      <= 1'b1;
							start_level_q <= '0;
							level_q       <= '0;
						end
						lae_pkg::CMD_RELEASE: begin
							note_held_q     <= 1'b0;
							start_level_q   <= level_q;
							release_count_q <= '0;
						end
						default: ;
					endcase
				end
				lae_pkg::OP_FINISH: begin
					case (seg_q)
						lae_pkg::SEG_ATTACK:
							level_q <= (ovf_q || work_q[lae_pkg::QUO_W-1]) ? lae_pkg::MAX_LEVEL
								: work_q[lae_pkg::LVL_W-1:0];
						lae_pkg::SEG_DECAY:
							level_q <= (work_q == '0) ? lae_pkg::MAX_LEVEL
								: lae_pkg::LVL_W'(lae_pkg::FULL_SCALE - work_q);
						lae_pkg::SEG_RAMP:
							level_q <= up_q ? decay_level_q + work_q[lae_pkg::LVL_W-1:0]
								: decay_level_q - work_q[lae_pkg::LVL_W-1:0];
						default: begin
							// release: drop of start level or more ends the note
							if (ovf_q || work_q >= {1'b0, start_level_q}) begin
								level_q  <= '0;
								active_q <= 1'b0;
							end else begin
								level_q <= start_level_q - work_q[lae_pkg::LVL_W-1:0];
							end
							if (release_count_q != lae_pkg::COUNT_MAX) begin
								release_count_q <= release_count_q + 24'd1;
							end
						end
					endcase
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= cmd.command;
			t_q   <= cmd.sample_time;
		end
		case (uw.op)
			lae_pkg::OP_DECODE: begin
				ad_q  <= {1'b0, attack_time_q} + {1'b0, decay_time_q};
				ads_q <= {2'b00, attack_time_q} + {2'b00, decay_time_q}
					+ {2'b00, sustain_time_q};
			end
			lae_pkg::OP_SELECT: begin
				up_q <= (sustain_level_q >= decay_level_q);
				if (!note_held_q) begin
					seg_q <= lae_pkg::SEG_RELEASE;
					x_q   <= release_count_q;
					y_q   <= {1'b0, start_level_q};
					div_q <= release_time_q;
				end else if (t_q <= attack_time_q) begin
					seg_q <= lae_pkg::SEG_ATTACK;
					x_q   <= t_q;
					y_q   <= lae_pkg::FULL_SCALE;
					div_q <= attack_time_q;
				end else if (t_ext < {1'b0, ad_q}) begin
					seg_q <= lae_pkg::SEG_DECAY;
					x_q   <= t_q - attack_time_q;
					y_q   <= lae_pkg::FULL_SCALE - {1'b0, decay_level_q};
					div_q <= decay_time_q;
				end else begin
					seg_q <= lae_pkg::SEG_RAMP;
					x_q   <= lae_pkg::TIME_W'(t_ext - {1'b0, ad_q});
					y_q   <= (sustain_level_q >= decay_level_q)
						? {1'b0, sustain_level_q - decay_level_q}
						: {1'b0, decay_level_q - sustain_level_q};
					div_q <= sustain_time_q;
				end
			end
			lae_pkg::OP_MUL: num_q <= prod;
			lae_pkg::OP_DIVINIT: begin
				// quotient must fit in 17 bits, else it saturates
				ovf_q  <= (num_q[lae_pkg::NUM_W-1:lae_pkg::QUO_W] >= div_q);
				rem_q  <= num_q[lae_pkg::NUM_W-1:lae_pkg::QUO_W];
				work_q <= num_q[lae_pkg::QUO_W-1:0];
				cnt_q  <= 5'(lae_pkg::QUO_W - 1);
			end
			lae_pkg::OP_DIVSTEP: begin
				rem_q  <= ge ? diff[lae_pkg::TIME_W-1:0] : shifted[lae_pkg::TIME_W-1:0];
				work_q <= {work_q[lae_pkg::QUO_W-2:0], ge};
				cnt_q  <= cnt_q - 5'd1;
			end
			lae_pkg::OP_EMIT: begin
				if (out_free) begin
					out_level_q   <= level_q;
					out_playing_q <= active_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/lae_checker.sv @@
// port-level checks of the envelope generator, bound to the top level
`default_nettype none
module lae_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [lae_pkg::LVL_W-1:0]  out_level,
	input wire logic                       out_playing
);

	// result held while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_level) && $stable(out_playing))
		else $error("stalled result changed");

	// one command at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken while another is in work");

	// a silent envelope sits at zero
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_playing |-> out_level == '0)
		else $error("non-zero level with playing flag clear");

endmodule

bind linear_adsr_envelope_top lae_checker u_lae_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (cmd.valid),
	.in_ready   (cmd.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.out_level  (res.level),
	.out_playing(res.playing)
);
`default_nettype wire
